FILE: rtl/assert_macros.svh
// Assertion macros for the buffer manager RTL.
// No dependencies; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LCBM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication
`define LCBM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/lcbm_pkg.sv
// Shared types and constants for the linked chunk buffer manager.
// No dependencies.
package lcbm_pkg;

  localparam int NODE_COUNT  = 256;
  localparam int CHUNK_COUNT = 1024;
  localparam int NODE_W      = $clog2(NODE_COUNT);
  localparam int CHUNK_W     = $clog2(CHUNK_COUNT);
  localparam int LINK_W      = CHUNK_W + 1;
  localparam int NCNT_W      = NODE_W + 1;
  localparam int CCNT_W      = CHUNK_W + 1;
  localparam int BYTES_W     = 22;
  localparam int CSIZE_W     = 13;
  localparam int PROD_W      = CCNT_W + CSIZE_W;
  localparam int DCNT_W      = $clog2(BYTES_W);

  localparam logic [LINK_W-1:0]  LINK_NIL    = '1;
  localparam logic [CSIZE_W-1:0] CHUNK_RESET = 13'd64;
  localparam logic [CSIZE_W-1:0] CHUNK_MAX   = 13'd4096;

  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_LOCATE  = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    DIV_REQ = 2'd0,
    DIV_OFF = 2'd1,
    DIV_LEN = 2'd2
  } div_sel_t;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_C_END,
    ST_A_GO,
    ST_A_DIV,
    ST_A_CHECK,
    ST_A_WALK,
    ST_A_STEP,
    ST_A_END,
    ST_FAIL,
    ST_R_READ,
    ST_R_FIRST,
    ST_R_WALK,
    ST_R_STEP,
    ST_R_END,
    ST_L_GO1,
    ST_L_DIV1,
    ST_L_GO2,
    ST_L_DIV2,
    ST_L_START,
    ST_L_WALK,
    ST_L_STEP,
    ST_L_END
  } ctrl_state_t;

  typedef struct packed {
    logic     capture;
    logic     sweep_step;
    logic     init_done;
    logic     div_go;
    div_sel_t div_sel;
    logic     save_ord;
    logic     alloc_start;
    logic     rel_start;
    logic     rel_none;
    logic     loc_start;
    logic     walk_step;
    logic     commit;
    logic     refuse;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic div_busy;
    logic div_done;
    logic alloc_ok;
    logic alloc_end;
    logic loc_end;
    logic link_ok;
    logic first_ok;
    logic rel_more;
    logic out_free;
  } sts_t;

  function automatic logic chunk_ok(input logic [LINK_W-1:0] link);
    chunk_ok = link < LINK_W'(CHUNK_COUNT);
  endfunction

endpackage

FILE: rtl/lcbm_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on lcbm_pkg.
module lcbm_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic [lcbm_pkg::BYTES_W-1:0]  dividend,
  input  logic [lcbm_pkg::CSIZE_W-1:0]  divisor,
  output logic                          busy,
  output logic                          done,
  output logic [lcbm_pkg::BYTES_W-1:0]  quot,
  output logic [lcbm_pkg::CSIZE_W-1:0]  rem
);
  import lcbm_pkg::*;

  logic                busy_r;
  logic                done_r;
  logic [DCNT_W-1:0]   cnt_r;
  logic [BYTES_W-1:0]  quot_r;
  logic [CSIZE_W-1:0]  rem_r;
  logic [CSIZE_W-1:0]  dvs_r;
  logic [CSIZE_W:0]    rem_sh;
  logic                fits;

  assign rem_sh = {rem_r, quot_r[BYTES_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(BYTES_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quot_r <= dividend;
      rem_r  <= '0;
      dvs_r  <= divisor;
    end else if (busy_r) begin
      quot_r <= {quot_r[BYTES_W-2:0], fits};
      rem_r  <= fits ? CSIZE_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[CSIZE_W-1:0];
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

FILE: rtl/lcbm_datapath.sv
// Datapath: free lists, link memories, counters, divider and result register.
// Depends on lcbm_pkg and lcbm_div.
module lcbm_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lcbm_pkg::CSIZE_W-1:0]  cfg_data,
  input  logic [1:0]                    in_operation,
  input  logic [lcbm_pkg::NODE_W-1:0]   in_node_id,
  input  logic [lcbm_pkg::BYTES_W-1:0]  in_request_bytes,
  input  logic [lcbm_pkg::BYTES_W-1:0]  in_byte_offset,
  input  lcbm_pkg::cmd_t                cmd,
  output lcbm_pkg::sts_t                sts,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic                          out_status,
  output logic [lcbm_pkg::NODE_W-1:0]   out_granted_node,
  output logic [lcbm_pkg::CHUNK_W-1:0]  out_chunk_id,
  output logic [lcbm_pkg::CHUNK_W-1:0]  out_chunk_ordinal,
  output logic [lcbm_pkg::CSIZE_W-1:0]  out_bytes_in_chunk,
  output logic [lcbm_pkg::BYTES_W-1:0]  out_stored_bytes,
  output logic [lcbm_pkg::CCNT_W-1:0]   out_chunk_total,
  output logic [lcbm_pkg::NCNT_W-1:0]   out_nodes_free,
  output logic [lcbm_pkg::CCNT_W-1:0]   out_chunks_free
);
  import lcbm_pkg::*;

  logic [CSIZE_W-1:0]  chunk_r;
  logic [CSIZE_W-1:0]  s_r;
  op_t                 op_r;
  logic [NODE_W-1:0]   node_r;
  logic [BYTES_W-1:0]  req_r;
  logic [BYTES_W-1:0]  off_r;
  logic [LINK_W-1:0]   fnt_r;
  logic [LINK_W-1:0]   fct_r;
  logic [NCNT_W-1:0]   an_r;
  logic [CCNT_W-1:0]   ac_r;
  logic [CHUNK_W-1:0]  idx_r;
  logic [LINK_W-1:0]   cur_r;
  logic [CCNT_W-1:0]   cnt_r;
  logic [LINK_W-1:0]   first_r;
  logic                ok_r;
  logic [BYTES_W-1:0]  ord_r;
  logic [CSIZE_W-1:0]  remo_r;
  logic [PROD_W-1:0]   prod_r;
  logic                out_valid_r;

  logic [LINK_W-1:0]   cn_mem [CHUNK_COUNT];
  logic [LINK_W-1:0]   nl_mem [NODE_COUNT];
  logic [BYTES_W-1:0]  len_mem [NODE_COUNT];
  logic [LINK_W-1:0]   cn_q;
  logic [LINK_W-1:0]   nl_q;
  logic [BYTES_W-1:0]  len_q;

  logic [BYTES_W-1:0]  div_a;
  logic                div_busy;
  logic                div_done;
  logic [BYTES_W-1:0]  div_q;
  logic [CSIZE_W-1:0]  div_r;
  logic [BYTES_W-1:0]  ceil_q;
  logic [BYTES_W-1:0]  need;

  logic [CSIZE_W-1:0]  s_eff;
  logic [NODE_W-1:0]   nl_raddr;
  logic                is_alloc;
  logic                is_rel;
  logic [NCNT_W-1:0]   an_alloc;
  logic [CCNT_W-1:0]   ac_alloc;
  logic [NCNT_W-1:0]   an_rel;
  logic [CCNT_W:0]     ac_sum;
  logic [CCNT_W-1:0]   ac_rel;
  logic                loc_hit;
  logic [CSIZE_W-1:0]  loc_bytes;

  logic                cn_we;
  logic [CHUNK_W-1:0]  cn_waddr;
  logic [LINK_W-1:0]   cn_wdata;
  logic                nl_we;
  logic [NODE_W-1:0]   nl_waddr;
  logic [LINK_W-1:0]   nl_wdata;
  logic [BYTES_W-1:0]  len_wdata;
  logic                in_low;

  logic                res_status;
  logic [NODE_W-1:0]   res_node;
  logic [CHUNK_W-1:0]  res_chunk;
  logic [CHUNK_W-1:0]  res_ord;
  logic [CSIZE_W-1:0]  res_bytes;
  logic [BYTES_W-1:0]  res_stored;
  logic [CCNT_W-1:0]   res_total;
  logic [NCNT_W-1:0]   res_nodes;
  logic [CCNT_W-1:0]   res_chunks;

  // zero acts as one, oversize clamps to the largest chunk
  assign s_eff = (chunk_r == '0) ? CSIZE_W'(1) :
                 (chunk_r > CHUNK_MAX) ? CHUNK_MAX : chunk_r;

  always_comb begin
    case (cmd.div_sel)
      DIV_REQ: div_a = req_r;
      DIV_OFF: div_a = off_r;
      DIV_LEN: div_a = len_q;
      default: div_a = req_r;
    endcase
  end

  lcbm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (cmd.div_go),
    .dividend (div_a),
    .divisor  (s_r),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  assign ceil_q   = div_q + BYTES_W'(div_r != '0);
  assign need     = (ceil_q == '0) ? BYTES_W'(1) : ceil_q;
  assign is_alloc = op_r == OP_ALLOC;
  assign is_rel   = op_r == OP_RELEASE;
  assign nl_raddr = is_alloc ? fnt_r[NODE_W-1:0] : node_r;

  assign an_alloc = an_r - 1'b1;
  assign ac_alloc = ({{(BYTES_W-CCNT_W){1'b0}}, ac_r} > need) ?
                    CCNT_W'(ac_r - need[CCNT_W-1:0]) : '0;
  assign an_rel   = (an_r < NCNT_W'(NODE_COUNT)) ? an_r + 1'b1 : an_r;
  assign ac_sum   = {1'b0, ac_r} + {1'b0, cnt_r};
  assign ac_rel   = (ac_sum > (CCNT_W+1)'(CHUNK_COUNT)) ? CCNT_W'(CHUNK_COUNT) :
                    ac_sum[CCNT_W-1:0];

  assign loc_hit = ok_r && (ord_r <= BYTES_W'(CHUNK_COUNT));
  always_comb begin
    if (off_r >= len_q) begin
      loc_bytes = '0;
    end else if (div_q != ord_r) begin
      loc_bytes = s_r - remo_r;
    end else if (div_r == '0) begin
      loc_bytes = s_r - remo_r;
    end else begin
      loc_bytes = div_r - remo_r;
    end
  end

  // memory write ports
  assign in_low = idx_r < CHUNK_W'(NODE_COUNT);
  always_comb begin
    cn_we     = cmd.sweep_step ||
                (cmd.commit && (is_alloc || (is_rel && cnt_r != '0)));
    cn_waddr  = cmd.sweep_step ? idx_r : cur_r[CHUNK_W-1:0];
    if (cmd.sweep_step) begin
      cn_wdata = (idx_r == CHUNK_W'(CHUNK_COUNT - 1)) ? LINK_NIL :
                 LINK_W'({1'b0, idx_r} + 1'b1);
    end else begin
      cn_wdata = is_alloc ? LINK_NIL : fct_r;
    end
    nl_we     = (cmd.sweep_step && in_low) || (cmd.commit && (is_alloc || is_rel));
    nl_waddr  = cmd.sweep_step ? idx_r[NODE_W-1:0] : nl_raddr;
    if (cmd.sweep_step) begin
      nl_wdata = (idx_r[NODE_W-1:0] == NODE_W'(NODE_COUNT - 1)) ? LINK_NIL :
                 LINK_W'({1'b0, idx_r[NODE_W-1:0]} + 1'b1);
    end else begin
      nl_wdata = is_alloc ? fct_r : fnt_r;
    end
    len_wdata = (!cmd.sweep_step && is_alloc) ? req_r : '0;
  end

  always_ff @(posedge clk) begin
    if (cn_we) begin
      cn_mem[cn_waddr] <= cn_wdata;
    end
    cn_q <= cn_mem[cur_r[CHUNK_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (nl_we) begin
      nl_mem[nl_waddr]  <= nl_wdata;
      len_mem[nl_waddr] <= len_wdata;
    end
    nl_q  <= nl_mem[nl_raddr];
    len_q <= len_mem[node_r];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_r     <= CHUNK_RESET;
      fnt_r       <= '0;
      fct_r       <= '0;
      an_r        <= NCNT_W'(NODE_COUNT);
      ac_r        <= CCNT_W'(CHUNK_COUNT);
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        chunk_r <= cfg_data;
      end
      if (cmd.capture) begin
        idx_r <= '0;
      end else if (cmd.sweep_step) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.init_done || (cmd.commit && op_r == OP_CLEAR)) begin
        fnt_r <= '0;
        fct_r <= '0;
        an_r  <= NCNT_W'(NODE_COUNT);
        ac_r  <= CCNT_W'(CHUNK_COUNT);
      end else if (cmd.commit && is_alloc) begin
        fnt_r <= nl_q;
        fct_r <= cn_q;
        an_r  <= an_alloc;
        ac_r  <= ac_alloc;
      end else if (cmd.commit && is_rel) begin
        if (cnt_r != '0) begin
          fct_r <= first_r;
        end
        fnt_r <= LINK_W'(node_r);
        an_r  <= an_rel;
        ac_r  <= ac_rel;
      end
      if (cmd.commit || cmd.refuse) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(ac_r) * PROD_W'(s_r);
    if (cmd.capture) begin
      op_r   <= op_t'(in_operation);
      node_r <= in_node_id;
      req_r  <= in_request_bytes;
      off_r  <= in_byte_offset;
      s_r    <= s_eff;
    end
    if (cmd.save_ord) begin
      ord_r  <= div_q;
      remo_r <= div_r;
    end
    if (cmd.alloc_start) begin
      cur_r <= fct_r;
      cnt_r <= CCNT_W'(1);
      ok_r  <= 1'b1;
    end else if (cmd.rel_start) begin
      cur_r   <= nl_q;
      first_r <= nl_q;
      cnt_r   <= CCNT_W'(1);
      ok_r    <= 1'b1;
    end else if (cmd.rel_none) begin
      cnt_r <= '0;
    end else if (cmd.loc_start) begin
      cur_r <= nl_q;
      cnt_r <= '0;
      ok_r  <= chunk_ok(nl_q);
    end else if (cmd.walk_step) begin
      cur_r <= cn_q;
      cnt_r <= cnt_r + 1'b1;
      ok_r  <= ok_r && chunk_ok(cn_q);
    end
    if (cmd.commit || cmd.refuse) begin
      out_status         <= res_status;
      out_granted_node   <= res_node;
      out_chunk_id       <= res_chunk;
      out_chunk_ordinal  <= res_ord;
      out_bytes_in_chunk <= res_bytes;
      out_stored_bytes   <= res_stored;
      out_chunk_total    <= res_total;
      out_nodes_free     <= res_nodes;
      out_chunks_free    <= res_chunks;
    end
  end

  always_comb begin
    res_status = STATUS_DONE;
    res_node   = '0;
    res_chunk  = '0;
    res_ord    = '0;
    res_bytes  = '0;
    res_stored = '0;
    res_total  = '0;
    res_nodes  = an_r;
    res_chunks = ac_r;
    if (cmd.refuse) begin
      res_status = STATUS_REFUSED;
    end else begin
      case (op_r)
        OP_ALLOC: begin
          res_node   = fnt_r[NODE_W-1:0];
          res_chunk  = fct_r[CHUNK_W-1:0];
          res_stored = req_r;
          res_total  = ceil_q[CCNT_W-1:0];
          res_nodes  = an_alloc;
          res_chunks = ac_alloc;
        end
        OP_RELEASE: begin
          res_nodes  = an_rel;
          res_chunks = ac_rel;
        end
        OP_LOCATE: begin
          res_chunk  = loc_hit ? cur_r[CHUNK_W-1:0] : '0;
          res_ord    = ord_r[CHUNK_W-1:0];
          res_bytes  = loc_bytes;
          res_stored = len_q;
          res_total  = ceil_q[CCNT_W-1:0];
        end
        OP_CLEAR: begin
          res_nodes  = NCNT_W'(NODE_COUNT);
          res_chunks = CCNT_W'(CHUNK_COUNT);
        end
        default: begin
          res_nodes = an_r;
        end
      endcase
    end
  end

  always_comb begin
    sts.sweep_last = idx_r == CHUNK_W'(CHUNK_COUNT - 1);
    sts.div_busy   = div_busy;
    sts.div_done   = div_done;
    sts.alloc_ok   = (an_r != '0) && (ac_r != '0) &&
                     (prod_r > PROD_W'(req_r)) &&
                     (fnt_r < LINK_W'(NODE_COUNT)) && chunk_ok(fct_r);
    sts.alloc_end  = BYTES_W'(cnt_r) == need;
    sts.loc_end    = !ok_r || (BYTES_W'(cnt_r) == ord_r) ||
                     (cnt_r == CCNT_W'(CHUNK_COUNT));
    sts.link_ok    = chunk_ok(cn_q);
    sts.first_ok   = chunk_ok(nl_q);
    sts.rel_more   = chunk_ok(cn_q) && (cnt_r < CCNT_W'(CHUNK_COUNT));
    sts.out_free   = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;

endmodule

FILE: rtl/lcbm_ctrl.sv
// Controller state machine sequencing each request through the datapath.
// Depends on lcbm_pkg and assert_macros.svh.
module lcbm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [1:0]      in_operation,
  output logic            in_stall,
  input  lcbm_pkg::sts_t  sts,
  output lcbm_pkg::cmd_t  cmd
);
  import lcbm_pkg::*;
  `include "assert_macros.svh"

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT:    if (sts.sweep_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          case (op_t'(in_operation))
            OP_ALLOC:   state_nxt = ST_A_GO;
            OP_RELEASE: state_nxt = ST_R_READ;
            OP_LOCATE:  state_nxt = ST_L_GO1;
            OP_CLEAR:   state_nxt = ST_CLEAR;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR:   if (sts.sweep_last) state_nxt = ST_C_END;
      ST_C_END:   if (sts.out_free) state_nxt = ST_IDLE;
      ST_A_GO:    state_nxt = ST_A_DIV;
      ST_A_DIV:   if (sts.div_done) state_nxt = ST_A_CHECK;
      ST_A_CHECK: state_nxt = sts.alloc_ok ? ST_A_WALK : ST_FAIL;
      ST_A_WALK:  state_nxt = sts.alloc_end ? ST_A_END : ST_A_STEP;
      ST_A_STEP:  state_nxt = sts.link_ok ? ST_A_WALK : ST_FAIL;
      ST_A_END:   if (sts.out_free) state_nxt = ST_IDLE;
      ST_FAIL:    if (sts.out_free) state_nxt = ST_IDLE;
      ST_R_READ:  state_nxt = ST_R_FIRST;
      ST_R_FIRST: state_nxt = sts.first_ok ? ST_R_WALK : ST_R_END;
      ST_R_WALK:  state_nxt = ST_R_STEP;
      ST_R_STEP:  state_nxt = sts.rel_more ? ST_R_WALK : ST_R_END;
      ST_R_END:   if (sts.out_free) state_nxt = ST_IDLE;
      ST_L_GO1:   state_nxt = ST_L_DIV1;
      ST_L_DIV1:  if (sts.div_done) state_nxt = ST_L_GO2;
      ST_L_GO2:   state_nxt = ST_L_DIV2;
      ST_L_DIV2:  if (sts.div_done) state_nxt = ST_L_START;
      ST_L_START: state_nxt = ST_L_WALK;
      ST_L_WALK:  state_nxt = sts.loc_end ? ST_L_END : ST_L_STEP;
      ST_L_STEP:  state_nxt = ST_L_WALK;
      ST_L_END:   if (sts.out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_INIT;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.div_sel = DIV_REQ;
    in_stall    = 1'b1;
    case (state_r)
      ST_INIT: begin
        cmd.sweep_step = 1'b1;
        cmd.init_done  = sts.sweep_last;
      end
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_CLEAR:   cmd.sweep_step = 1'b1;
      ST_C_END:   cmd.commit = sts.out_free;
      ST_A_GO:    cmd.div_go = 1'b1;
      ST_A_CHECK: cmd.alloc_start = sts.alloc_ok;
      ST_A_STEP:  cmd.walk_step = sts.link_ok;
      ST_A_END:   cmd.commit = sts.out_free;
      ST_FAIL:    cmd.refuse = sts.out_free;
      ST_R_FIRST: begin
        cmd.rel_start = sts.first_ok;
        cmd.rel_none  = !sts.first_ok;
      end
      ST_R_STEP:  cmd.walk_step = sts.rel_more;
      ST_R_END:   cmd.commit = sts.out_free;
      ST_L_GO1: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DIV_OFF;
      end
      ST_L_DIV1:  cmd.save_ord = sts.div_done;
      ST_L_GO2: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DIV_LEN;
      end
      ST_L_START: cmd.loc_start = 1'b1;
      ST_L_STEP:  cmd.walk_step = 1'b1;
      ST_L_END:   cmd.commit = sts.out_free;
      default:    cmd.div_sel = DIV_REQ;
    endcase
  end

  `LCBM_ASSERT_IMP(a_result_slot_free, clk, rst_n, cmd.commit || cmd.refuse, sts.out_free)
  `LCBM_ASSERT_IMP(a_div_not_busy, clk, rst_n, cmd.div_go, !sts.div_busy)
  `LCBM_ASSERT_NXT(a_stall_after_capture, clk, rst_n, cmd.capture, in_stall)

endmodule

FILE: rtl/linked_chunk_buffer_manager.sv
// Linked chunk buffer manager: one request at a time. After reset, and for
// every clear request, a pass over the chunk link memory rebuilds the free
// lists, with the input stalled. Allocate runs the 22-step bit-serial
// divider and then walks the chain over the chunk link memory, one
// registered read per link. Release walks the node's chunk chain, and
// locate runs two divides plus the walk. Each request's end state waits
// while the output register still holds a stalled result. A finished
// result sits in an output register, so the next request can be taken
// while it waits.
// Top level; depends on lcbm_pkg, lcbm_ctrl, lcbm_datapath.
module linked_chunk_buffer_manager (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lcbm_pkg::CSIZE_W-1:0]  cfg_chunk_bytes,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_operation,
  input  logic [lcbm_pkg::NODE_W-1:0]   in_node_id,
  input  logic [lcbm_pkg::BYTES_W-1:0]  in_request_bytes,
  input  logic [lcbm_pkg::BYTES_W-1:0]  in_byte_offset,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_status,
  output logic [lcbm_pkg::NODE_W-1:0]   out_granted_node,
  output logic [lcbm_pkg::CHUNK_W-1:0]  out_chunk_id,
  output logic [lcbm_pkg::CHUNK_W-1:0]  out_chunk_ordinal,
  output logic [lcbm_pkg::CSIZE_W-1:0]  out_bytes_in_chunk,
  output logic [lcbm_pkg::BYTES_W-1:0]  out_stored_bytes,
  output logic [lcbm_pkg::CCNT_W-1:0]   out_chunk_total,
  output logic [lcbm_pkg::NCNT_W-1:0]   out_nodes_free,
  output logic [lcbm_pkg::CCNT_W-1:0]   out_chunks_free
);
  import lcbm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  lcbm_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  lcbm_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_valid & cfg_ready),
    .cfg_data           (cfg_chunk_bytes),
    .in_operation       (in_operation),
    .in_node_id         (in_node_id),
    .in_request_bytes   (in_request_bytes),
    .in_byte_offset     (in_byte_offset),
    .cmd                (cmd),
    .sts                (sts),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_granted_node   (out_granted_node),
    .out_chunk_id       (out_chunk_id),
    .out_chunk_ordinal  (out_chunk_ordinal),
    .out_bytes_in_chunk (out_bytes_in_chunk),
    .out_stored_bytes   (out_stored_bytes),
    .out_chunk_total    (out_chunk_total),
    .out_nodes_free     (out_nodes_free),
    .out_chunks_free    (out_chunks_free)
  );

endmodule

FILE: test/linked_chunk_buffer_manager_tb.sv
// Testbench for linked_chunk_buffer_manager: directed table, then random
// allocate/release/locate/clear traffic checked against an in-bench model.
// Depends on lcbm_pkg and the RTL under rtl/.
module linked_chunk_buffer_manager_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lcbm_pkg::*;

  localparam int unsigned NIL        = 32'hFFFF_FFFF;
  localparam int          MAX_CYCLES = 20_000_000;
  localparam int          PHASE_LEN  = 275;

  typedef struct {
    logic        status;
    logic [7:0]  granted_node;
    logic [9:0]  chunk_id;
    logic [9:0]  chunk_ordinal;
    logic [12:0] bytes_in_chunk;
    logic [21:0] stored_bytes;
    logic [10:0] chunk_total;
    logic [8:0]  nodes_free;
    logic [10:0] chunks_free;
  } result_t;

  typedef struct {
    op_t         op;
    logic [7:0]  node;
    logic [21:0] req;
    logic [21:0] off;
    bit          typed;
    result_t     res;
  } stim_row_t;

  logic        clk, rst_n;
  logic        cfg_valid, cfg_ready;
  logic [12:0] cfg_chunk_bytes;
  logic        in_valid, in_stall;
  logic [1:0]  in_operation;
  logic [7:0]  in_node_id;
  logic [21:0] in_request_bytes, in_byte_offset;
  logic        out_valid, out_stall, out_status;
  logic [7:0]  out_granted_node;
  logic [9:0]  out_chunk_id, out_chunk_ordinal;
  logic [12:0] out_bytes_in_chunk;
  logic [21:0] out_stored_bytes;
  logic [10:0] out_chunk_total, out_chunks_free;
  logic [8:0]  out_nodes_free;

  linked_chunk_buffer_manager uut (.*);

  // model state
  int unsigned node_link [NODE_COUNT];
  int unsigned node_len [NODE_COUNT];
  int unsigned chunk_link [CHUNK_COUNT];
  int unsigned node_top, chunk_top, nodes_avail, chunks_avail;
  logic [12:0] chunk_reg;
  int unsigned live_nodes[$];

  result_t     pending_results[$];
  stim_row_t   directed[$];
  int          errors = 0;
  int          accepted_in = 0;
  int          cycles = 0;
  bit          quiet = 0;
  bit          long_hold_done = 0;

  function automatic void rebuild_lists();
    for (int i = 0; i < NODE_COUNT; i++) begin
      node_link[i] = (i + 1 < NODE_COUNT) ? i + 1 : NIL;
      node_len[i] = 0;
    end
    for (int i = 0; i < CHUNK_COUNT; i++) chunk_link[i] = (i + 1 < CHUNK_COUNT) ? i + 1 : NIL;
    node_top = 0;
    chunk_top = 0;
    nodes_avail = NODE_COUNT;
    chunks_avail = CHUNK_COUNT;
    live_nodes.delete();
  endfunction

  function automatic longint unsigned chunk_size();
    if (chunk_reg == 0) return 1;
    if (chunk_reg > 4096) return 4096;
    return 64'(chunk_reg);
  endfunction

  function automatic result_t predict_result(op_t op, logic [7:0] node, logic [21:0] req,
                                             logic [21:0] off);
    result_t res;
    longint unsigned s, need, len, ord, rem, bytes, freed, t;
    int unsigned c, n, first;
    bit ok;
    res = '{default: 0};
    s = chunk_size();
    case (op)
      OP_ALLOC: begin
        need = (req > s) ? (req + s - 1) / s : 1;
        ok = nodes_avail != 0 && chunks_avail != 0 && longint'(chunks_avail) * s > req &&
             node_top < NODE_COUNT && chunk_top < CHUNK_COUNT;
        c = chunk_top;
        if (ok) begin
          for (longint unsigned i = 1; i < need; i++) begin
            if (c >= CHUNK_COUNT || i > CHUNK_COUNT) begin
              ok = 0;
              break;
            end
            c = chunk_link[c];
          end
          if (c >= CHUNK_COUNT) ok = 0;
        end
        if (!ok) begin
          res.status = STATUS_REFUSED;
        end else begin
          n = node_top;
          node_top = node_link[n];
          node_link[n] = chunk_top;
          node_len[n] = 32'(req);
          res.granted_node = 8'(n);
          res.chunk_id = 10'(chunk_top);
          res.stored_bytes = req;
          res.chunk_total = 11'((req + s - 1) / s);
          chunk_top = chunk_link[c];
          chunk_link[c] = NIL;
          nodes_avail--;
          chunks_avail = (chunks_avail > need) ? 32'(chunks_avail - need) : 0;
          live_nodes.push_back(n);
        end
      end
      OP_RELEASE: begin
        first = node_link[node];
        freed = 0;
        // an unallocated node's free-list link is walked as a chunk chain
        if (first < CHUNK_COUNT) begin
          c = first;
          freed = 1;
          while (chunk_link[c] < CHUNK_COUNT && freed < CHUNK_COUNT) begin
            c = chunk_link[c];
            freed++;
          end
          chunk_link[c] = chunk_top;
          chunk_top = first;
        end
        node_link[node] = node_top;
        node_len[node] = 0;
        node_top = 32'(node);
        if (nodes_avail < NODE_COUNT) nodes_avail++;
        t = chunks_avail + freed;
        chunks_avail = (t > CHUNK_COUNT) ? CHUNK_COUNT : 32'(t);
        for (int i = live_nodes.size() - 1; i >= 0; i--)
          if (live_nodes[i] == node) live_nodes.delete(i);
      end
      OP_LOCATE: begin
        len = node_len[node];
        ord = off / s;
        rem = off % s;
        c = node_link[node];
        ok = c < CHUNK_COUNT;
        for (longint unsigned i = 0; ok && i < ord; i++) begin
          if (i >= CHUNK_COUNT) begin
            ok = 0;
            break;
          end
          c = chunk_link[c];
          if (c >= CHUNK_COUNT) ok = 0;
        end
        if (off >= len) bytes = 0;
        else if (len / s != ord) bytes = s - rem;
        else bytes = (len % s == 0) ? s - rem : (len % s) - rem;
        res.chunk_id = ok ? 10'(c) : 10'd0;
        res.chunk_ordinal = 10'(ord);
        res.bytes_in_chunk = 13'(bytes);
        res.stored_bytes = 22'(len);
        res.chunk_total = 11'((len + s - 1) / s);
      end
      default: rebuild_lists();
    endcase
    res.nodes_free = 9'(nodes_avail);
    res.chunks_free = 11'(chunks_avail);
    return res;
  endfunction

  task automatic report(string field, longint unsigned got, longint unsigned want);
    errors++;
    $display("[%0t] %s: got %0d, expected %0d", $realtime, field, got, want);
  endtask

  // clock, cycle limit
  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", out_status, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) report("status", out_status, want.status);
        if (out_granted_node !== want.granted_node)
          report("granted_node", out_granted_node, want.granted_node);
        if (out_chunk_id !== want.chunk_id) report("chunk_id", out_chunk_id, want.chunk_id);
        if (out_chunk_ordinal !== want.chunk_ordinal)
          report("chunk_ordinal", out_chunk_ordinal, want.chunk_ordinal);
        if (out_bytes_in_chunk !== want.bytes_in_chunk)
          report("bytes_in_chunk", out_bytes_in_chunk, want.bytes_in_chunk);
        if (out_stored_bytes !== want.stored_bytes)
          report("stored_bytes", out_stored_bytes, want.stored_bytes);
        if (out_chunk_total !== want.chunk_total)
          report("chunk_total", out_chunk_total, want.chunk_total);
        if (out_nodes_free !== want.nodes_free)
          report("nodes_free", out_nodes_free, want.nodes_free);
        if (out_chunks_free !== want.chunks_free)
          report("chunks_free", out_chunks_free, want.chunks_free);
      end
    end
  end

  // result side stalls, with one long hold-off that backs up the input
  initial begin
    out_stall = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!long_hold_done && accepted_in >= 200) begin
        long_hold_done = 1;
        out_stall <= 1;
        repeat (400) @(negedge clk);
        out_stall <= 0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        out_stall <= 0;
      end else begin
        out_stall <= 0;
      end
    end
  end

  task automatic send_request(op_t op, logic [7:0] node, logic [21:0] req, logic [21:0] off,
                              bit typed, result_t typed_res);
    result_t res;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid <= 1;
    in_operation <= op;
    in_node_id <= node;
    in_request_bytes <= req;
    in_byte_offset <= off;
    do @(posedge clk); while (in_stall);
    accepted_in++;
    res = predict_result(op, node, req, off);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    wait (pending_results.size() == 0);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_chunk_bytes(logic [12:0] value);
    drain();
    cfg_valid <= 1;
    cfg_chunk_bytes <= value;
    do @(posedge clk); while (!cfg_ready);
    chunk_reg = value;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  function automatic result_t counts_only(logic status, int unsigned nf, int unsigned cf);
    result_t r;
    r = '{default: 0};
    r.status = status;
    r.nodes_free = 9'(nf);
    r.chunks_free = 11'(cf);
    return r;
  endfunction

  function automatic void add_row(op_t op, logic [7:0] node, logic [21:0] req,
                                  logic [21:0] off, bit typed, result_t res);
    stim_row_t row;
    row = '{op: op, node: node, req: req, off: off, typed: typed, res: res};
    directed.push_back(row);
  endfunction

  task automatic random_request();
    int unsigned r, m, node, len;
    longint unsigned s, req, off;
    s = chunk_size();
    r = $urandom_range(0, 99);
    if (r < 2) begin
      send_request(OP_CLEAR, 8'($urandom), 22'($urandom), 22'($urandom), 0, '{default: 0});
    end else if (r < 42) begin
      m = $urandom_range(0, 19);
      if (m < 13) req = $urandom_range(0, 32'(s * 6));
      else if (m < 16) req = s * $urandom_range(1, 8);
      else if (m < 18) req = $urandom_range(0, (s * 60 > 4194303) ? 4194303 : 32'(s * 60));
      else req = $urandom_range(0, 4194303);
      send_request(OP_ALLOC, 8'($urandom), 22'(req), 22'($urandom), 0, '{default: 0});
    end else if (r < 70) begin
      if (live_nodes.size() != 0 && r % 10 != 0)
        node = live_nodes[$urandom_range(0, live_nodes.size() - 1)];
      else node = $urandom_range(0, 255);
      send_request(OP_RELEASE, 8'(node), 22'($urandom), 22'($urandom), 0, '{default: 0});
    end else begin
      if (live_nodes.size() != 0 && r % 10 != 0)
        node = live_nodes[$urandom_range(0, live_nodes.size() - 1)];
      else node = $urandom_range(0, 255);
      len = node_len[node];
      m = $urandom_range(0, 9);
      if (m < 8) off = $urandom_range(0, (len != 0) ? len - 1 : 0);
      else if (m < 9) off = len + $urandom_range(0, 32'(s * 2));
      else off = $urandom_range(0, 4194303);
      if (off > 4194303) off = 4194303;
      send_request(OP_LOCATE, 8'(node), 22'($urandom), 22'(off), 0, '{default: 0});
    end
  endtask

  initial begin
    logic [12:0] sizes [6];
    rst_n = 0;
    cfg_valid = 0;
    cfg_chunk_bytes = 0;
    in_valid = 0;
    in_operation = OP_ALLOC;
    in_node_id = 0;
    in_request_bytes = 0;
    in_byte_offset = 0;
    chunk_reg = CHUNK_RESET;
    rebuild_lists();
    repeat (12) @(negedge clk);
    rst_n = 1;

    // directed part, chunk size at its reset value
    add_row(OP_ALLOC, 0, 0, 0, 1, counts_only(STATUS_DONE, 255, 1023));
    add_row(OP_ALLOC, 0, 22'h3FFFFF, 0, 1, counts_only(STATUS_REFUSED, 255, 1023));
    add_row(OP_ALLOC, 0, 65535, 0, 0, '{default: 0});
    add_row(OP_ALLOC, 0, 100, 0, 0, '{default: 0});
    add_row(OP_LOCATE, 1, 0, 99, 0, '{default: 0});
    add_row(OP_LOCATE, 1, 0, 64, 0, '{default: 0});
    add_row(OP_LOCATE, 1, 0, 200, 0, '{default: 0});
    add_row(OP_LOCATE, 255, 0, 22'h3FFFFF, 0, '{default: 0});
    add_row(OP_RELEASE, 0, 0, 0, 0, '{default: 0});
    add_row(OP_RELEASE, 1, 0, 0, 0, '{default: 0});
    add_row(OP_RELEASE, 200, 0, 0, 0, '{default: 0});
    add_row(OP_CLEAR, 0, 0, 0, 1, counts_only(STATUS_DONE, 256, 1024));
    add_row(OP_ALLOC, 0, 65471, 0, 0, '{default: 0});
    add_row(OP_ALLOC, 0, 64, 0, 0, '{default: 0});
    add_row(OP_ALLOC, 0, 1, 0, 0, '{default: 0});
    add_row(OP_LOCATE, 0, 0, 65470, 0, '{default: 0});
    add_row(OP_RELEASE, 0, 0, 0, 0, '{default: 0});
    add_row(OP_ALLOC, 0, 5000, 0, 0, '{default: 0});
    add_row(OP_CLEAR, 255, 22'h3FFFFF, 22'h3FFFFF, 1, counts_only(STATUS_DONE, 256, 1024));
    foreach (directed[i])
      send_request(directed[i].op, directed[i].node, directed[i].req, directed[i].off,
                   directed[i].typed, directed[i].res);

    // random phases over several chunk sizes, extremes and out-of-range values among them
    sizes = '{13'd1, 13'd4096, 13'd0, 13'h1FFF, 13'd64, 13'd0};
    sizes[5] = 13'($urandom_range(2, 4095));
    for (int p = 0; p < 6; p++) begin
      write_chunk_bytes(sizes[p]);
      if (p == 5) quiet = 1;
      for (int k = 0; k < PHASE_LEN; k++) random_request();
    end

    drain();
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
